// ===== src/pse_pkg.sv =====
package pse_pkg;

  localparam int unsigned StackDepth = 32;
  localparam int unsigned PtrW       = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5,
    OP_END  = 3'd6,
    OP_NONE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_MISSING   = 3'd3,
    ST_FULL      = 3'd4,
    ST_MALFORMED = 3'd5,
    ST_RSVD6     = 3'd6,
    ST_RSVD7     = 3'd7
  } status_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [63:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [2:0]         status;
  } out_item_t;

endpackage

// ===== src/postfix_stack_evaluator.sv =====
// Postfix evaluator: one token per transaction, one shared add/subtract unit.
// Push tokens and tokens ignored or failed at once finish in S_IDLE; end tokens
// pass S_END and S_OUT, waiting for the previous result to leave the output
// register; one token in flight. A zero divisor stops the token at S_LOAD;
// multiply (shift-add) and divide/modulo (restoring) run 64 iterations.
// Reset (rst_n low, synchronous) empties the stack and clears the sticky error.
module postfix_stack_evaluator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pse_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pse_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_R, S_RD_L, S_LOAD, S_ITER, S_FIX, S_WB, S_END, S_OUT
  } state_t;

  state_t                         state_r;
  logic [pse_pkg::CountW-1:0]     count_r;
  pse_pkg::status_t               err_r;
  logic [2:0]                     op_r;
  logic [63:0]                    left_r, right_r;
  logic [63:0]                    acc_r, rem_r, mag_r;
  logic [64:0]                    wide_r;
  logic [6:0]                     iter_r;
  logic                           ovf_r;
  logic                           out_valid_r;
  pse_pkg::out_item_t             out_r;

  // stack memory and registered read
  logic [63:0]                    mem [pse_pkg::StackDepth];
  logic [pse_pkg::PtrW-1:0]       rd_addr;
  logic [63:0]                    rd_data_r;
  logic                           wr_en;
  logic [pse_pkg::PtrW-1:0]       wr_addr;
  logic [63:0]                    wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // shared 65-bit adder
  logic [64:0] add_a, add_b, add_s;
  logic        add_sub;
  assign add_s = add_sub ? (add_a - add_b) : (add_a + add_b);

  logic ln, rn, neg;
  logic [63:0] ml, mr;
  assign ln  = left_r[63];
  assign rn  = right_r[63];
  assign neg = ln ^ rn;
  assign ml  = ln ? (64'd0 - left_r) : left_r;
  assign mr  = rn ? (64'd0 - right_r) : right_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // memory addressing
  always_comb begin
    rd_addr = '0;
    if (state_r == S_IDLE)
      rd_addr = pse_pkg::PtrW'(count_r - pse_pkg::CountW'(1));
    else if (state_r == S_RD_R)
      rd_addr = pse_pkg::PtrW'(count_r - pse_pkg::CountW'(2));
    else if (state_r == S_END)
      rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pse_pkg::PtrW'(count_r - pse_pkg::CountW'(2));
    wr_data = acc_r;
    if (state_r == S_IDLE && in_valid && in_data.operation == pse_pkg::OP_PUSH &&
        err_r == pse_pkg::ST_OK && count_r < pse_pkg::CountW'(pse_pkg::StackDepth)) begin
      wr_en   = 1'b1;
      wr_addr = pse_pkg::PtrW'(count_r);
      wr_data = in_data.operand_value;
    end else if (state_r == S_WB && !ovf_r) begin
      wr_en = 1'b1;
    end
  end

  // adder operand selection
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        add_a   = {left_r[63], left_r};
        add_b   = {right_r[63], right_r};
        add_sub = (op_r == pse_pkg::OP_SUB);
      end
      S_ITER: begin
        if (op_r == pse_pkg::OP_MUL) begin
          add_a = {wide_r[63:0], 1'b0};
          add_b = mag_r[63] ? {1'b0, ml} : 65'd0;
        end else begin
          add_a   = {rem_r, mag_r[63]};
          add_b   = {1'b0, mr};
          add_sub = 1'b1;
        end
      end
      S_FIX: begin
        if (op_r == pse_pkg::OP_MOD) begin
          add_a = {1'b1, 64'd0 - rem_r};
          add_b = {right_r[63], right_r};
        end else begin
          add_a   = 65'd0;
          add_b   = wide_r;
          add_sub = neg;
          if (!neg) add_b = wide_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= pse_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      // raise a new result once the slot is free, drop a delivered one
      if (state_r == S_OUT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_data.operation;
            if (in_data.operation == pse_pkg::OP_END) begin
              state_r <= S_END;
            end else if (in_data.operation == pse_pkg::OP_PUSH) begin
              if (err_r == pse_pkg::ST_OK) begin
                if (count_r < pse_pkg::CountW'(pse_pkg::StackDepth))
                  count_r <= count_r + pse_pkg::CountW'(1);
                else
                  err_r <= pse_pkg::ST_FULL;
              end
            end else if (in_data.operation != pse_pkg::OP_NONE &&
                         err_r == pse_pkg::ST_OK) begin
              if (count_r < pse_pkg::CountW'(2)) err_r <= pse_pkg::ST_MISSING;
              else state_r <= S_RD_R;
            end
          end
        end
        S_RD_R: begin
          // top of stack arrives first
          right_r <= rd_data_r;
          state_r <= S_RD_L;
        end
        S_RD_L: begin
          left_r  <= rd_data_r;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          iter_r <= 7'd0;
          if (op_r == pse_pkg::OP_ADD || op_r == pse_pkg::OP_SUB) begin
            acc_r   <= add_s[63:0];
            ovf_r   <= add_s[64] ^ add_s[63];
            state_r <= S_WB;
          end else if (op_r != pse_pkg::OP_MUL && mr == 64'd0) begin
            err_r   <= pse_pkg::ST_DIVZERO;
            state_r <= S_IDLE;
          end else begin
            ovf_r   <= 1'b0;
            mag_r   <= (op_r == pse_pkg::OP_MUL) ? mr : ml;
            wide_r  <= '0;
            rem_r   <= '0;
            acc_r   <= '0;
            state_r <= S_ITER;
          end
        end
        S_ITER: begin
          mag_r  <= {mag_r[62:0], 1'b0};
          iter_r <= iter_r + 7'd1;
          if (op_r == pse_pkg::OP_MUL) begin
            wide_r <= {1'b0, add_s[63:0]};
            if (wide_r[63] || add_s[64]) ovf_r <= 1'b1;
          end else if (!add_s[64]) begin
            rem_r <= add_s[63:0];
            acc_r <= {acc_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[62:0], mag_r[63]};
            acc_r <= {acc_r[62:0], 1'b0};
          end
          if (iter_r == 7'd63) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          state_r <= S_WB;
          if (op_r == pse_pkg::OP_MUL) begin
            acc_r <= add_s[63:0];
            if (ovf_r || (!neg && wide_r[63]) ||
                (neg && wide_r[63] && wide_r[62:0] != 63'd0))
              ovf_r <= 1'b1;
          end else if (op_r == pse_pkg::OP_DIV) begin
            acc_r <= neg ? (64'd0 - acc_r) : acc_r;
            if (!neg && acc_r[63]) ovf_r <= 1'b1;
          end else begin
            if (ln && rem_r != 64'd0) begin
              acc_r <= add_s[63:0];
              if (rn && !add_s[63]) ovf_r <= 1'b1;
            end else begin
              acc_r <= rem_r;
            end
          end
        end
        S_WB: begin
          if (ovf_r) err_r <= pse_pkg::ST_OVERFLOW;
          else count_r <= count_r - pse_pkg::CountW'(1);
          state_r <= S_IDLE;
        end
        S_END: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            if (err_r != pse_pkg::ST_OK) begin
              out_r.status       <= err_r;
              out_r.result_value <= '0;
            end else if (count_r == pse_pkg::CountW'(1)) begin
              out_r.status       <= pse_pkg::ST_OK;
              out_r.result_value <= rd_data_r;
            end else begin
              out_r.status       <= pse_pkg::ST_MALFORMED;
              out_r.result_value <= '0;
            end
            count_r <= '0;
            err_r   <= pse_pkg::ST_OK;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
